// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the controller of the coefficient generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/core/bcaa_pkg.sv =====
// Types, widths and codes shared by the coefficient generator modules.
package bcaa_pkg;

  localparam int LEN_W       = 13;
  localparam int DEST_W      = 12;
  localparam int SRC_W       = 12;
  localparam int HALF_W      = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int FS_W   = 37;  // scale, fs, centre and every divisor
  localparam int AD_W   = 38;  // distance magnitude
  localparam int POS_W  = 40;  // signed positions
  localparam int COL_W  = 15;  // tap bounds in samples
  localparam int NUM_W  = 64;  // left-aligned dividend
  localparam int STEP_W = 7;
  localparam int QUO_W  = 38;
  localparam int T_W    = 25;
  localparam int T2_W   = 32;
  localparam int T3_W   = 33;
  localparam int K_W    = 32;
  localparam int KV_W   = 38;
  localparam int SUM_W  = 38;
  localparam int BPOS_W = 6;
  localparam int EXP_W  = 6;
  localparam int KEEP_W = 11;

  localparam logic [STEP_W-1:0] STEPS_SCALE  = STEP_W'(37);
  localparam logic [STEP_W-1:0] STEPS_CENTRE = STEP_W'(49);
  localparam logic [STEP_W-1:0] STEPS_TAP    = STEP_W'(62);
  localparam logic [STEP_W-1:0] STEPS_RATIO  = STEP_W'(64);
  localparam logic [BPOS_W-1:0] RATIO_TOP    = BPOS_W'(56);
  localparam logic [BPOS_W-1:0] KEEP_POS     = BPOS_W'(KEEP_W);

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_LENGTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LENGTH = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    DIV_SCALE,
    DIV_CENTRE,
    DIV_TAP,
    DIV_RATIO
  } div_op_t;

  typedef struct packed {
    logic    load_req;
    logic    div_start;
    div_op_t div_op;
    logic    cap_scale;
    logic    cap_centre;
    logic    calc_bounds;
    logic    calc_range;
    logic    tap_init;
    logic    tap_dist;
    logic    cap_t;
    logic    mul_sq;
    logic    mul_cube;
    logic    kern_wr;
    logic    idx_clr;
    logic    rd_tap;
    logic    emit;
    logic    emit_bad;
  } cmd_t;

  typedef struct packed {
    logic req_bad;
    logic range_bad;
    logic div_busy;
    logic div_done;
    logic tap_last;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/bicubic_aa_coefficient_generator.sv =====
// Top level of the antialiased bicubic resampling coefficient generator.
// Program input_length (index 0) and output_length (index 1) on the cfg channel while
// the block is idle; both reset to 1 and cfg_ready is always high.
// Each in beat carries one destination index. The block answers with one out beat per
// filter tap: source index and fp16 weight in out_tdata, out_tlast on the final tap.
// A rejected request answers with a single beat, out_tuser high and out_tlast high.
// One request is worked on at a time; in_tready is high only while the block is idle.
// Setup runs two serial divisions, for the scale and for the centre. Each tap then
// takes one division in the kernel pass and one more in the weight pass, both done
// by the one-bit-per-cycle divider. A request rejected on its index or the lengths
// answers from the check, before any division starts; one rejected on its tap range
// answers after the setup.
// Results leave through an output register; when the receiver stalls, the weight pass
// holds until that register frees up, and the last result may still wait there while
// the next request is accepted.
// Reset returns the controller to idle, empties the output register and sets both
// lengths to 1.
module bicubic_aa_coefficient_generator #(
  parameter int MAX_LENGTH = 4096,
  parameter int MAX_TAPS   = 61
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bcaa_pkg::IN_TDATA_W-1:0]  in_tdata,   // [11:0] dest_index
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bcaa_pkg::OUT_TDATA_W-1:0] out_tdata,  // [11:0] source_index, [27:12] weight_half
  output logic [0:0]                       out_tuser,  // [0] bad_request
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bcaa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bcaa_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bcaa_pkg::*;

  cmd_t    cmd;
  status_t st;

  bcaa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  bcaa_dp #(
    .MAX_LENGTH (MAX_LENGTH),
    .MAX_TAPS   (MAX_TAPS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/core/bcaa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bcaa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/bcaa_div.sv =====
// Restoring divider, one quotient bit per cycle, dividend fed MSB first.
module bcaa_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bcaa_pkg::NUM_W-1:0]  num,
  input  logic [bcaa_pkg::STEP_W-1:0] steps,
  input  logic [bcaa_pkg::FS_W-1:0]   divisor,
  output logic                        busy,
  output logic                        done,
  output logic                        step_bit,
  output logic [bcaa_pkg::QUO_W-1:0]  quo,
  output logic                        rem_nz
);
  import bcaa_pkg::*;

  logic [NUM_W-1:0]  num_r;
  logic [FS_W-1:0]   rem_r, den_r, rem_nxt;
  logic [QUO_W-1:0]  quo_r;
  logic [STEP_W-1:0] cnt_r, steps_r;
  logic              busy_r, done_r;
  logic [FS_W:0]     trial, diff;
  logic              ge;

  assign trial   = {rem_r, num_r[NUM_W-1]};
  assign ge      = trial >= {1'b0, den_r};
  assign diff    = trial - {1'b0, den_r};
  assign rem_nxt = ge ? diff[FS_W-1:0] : trial[FS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == steps_r - 1'b1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r   <= num;
      rem_r   <= '0;
      den_r   <= divisor;
      quo_r   <= '0;
      steps_r <= steps;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign step_bit = ge;
  assign quo      = quo_r;
  assign rem_nz   = |rem_r;

endmodule

// ===== rtl/core/bcaa_dp.sv =====
// Datapath: configuration registers, range setup, kernel taps, fp16 weights, output register.
module bcaa_dp #(
  parameter int MAX_LENGTH = 4096,
  parameter int MAX_TAPS   = 61
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bcaa_pkg::cmd_t                   cmd,
  output bcaa_pkg::status_t                st,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bcaa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bcaa_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [bcaa_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bcaa_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [0:0]                       out_tuser,
  output logic                             out_tlast
);
  import bcaa_pkg::*;

  localparam int IDX_W  = $clog2(MAX_TAPS + 1);
  localparam int ADDR_W = $clog2(MAX_TAPS);

  // Configuration and request
  logic [LEN_W-1:0]  il_r, ol_r;
  logic [DEST_W-1:0] dest_r;

  // Setup results
  logic [FS_W-1:0]          fs_r, centre_r;
  logic signed [POS_W-1:0]  lo_r;
  logic [POS_W-1:0]         hi_r;
  logic [COL_W-1:0]         xmin_r, xmax_r;

  // Tap loop
  logic [IDX_W-1:0]        idx_r;
  logic [AD_W-1:0]         ad_r;
  logic                    inr_r;
  logic [T_W-1:0]          t_r;
  logic [T2_W-1:0]         t2_r;
  logic [T3_W-1:0]         t3_r;
  logic signed [SUM_W-1:0] sum_r;

  // Weight rounding
  div_op_t           op_r;
  logic              neg_r, kzero_r;
  logic              started_r, rb_got_r, rb_r, stk_r;
  logic [BPOS_W-1:0] bpos_r;
  logic [EXP_W-1:0]  exp_r;
  logic [KEEP_W-1:0] keep_r;
  logic [3:0]        kcnt_r;

  // Output register
  logic              out_valid_r, out_last_r, out_bad_r;
  logic [SRC_W-1:0]  out_src_r;
  logic [HALF_W-1:0] out_w_r;

  // Divider and tap memory
  logic [NUM_W-1:0]  div_num;
  logic [STEP_W-1:0] div_steps;
  logic [FS_W-1:0]   div_den;
  logic              div_busy, div_done, div_bit, div_rem_nz;
  logic [QUO_W-1:0]  div_quo;
  logic [K_W-1:0]    ram_rdata;

  // Combinational helpers
  logic [2*LEN_W-1:0]      cprod;
  logic [COL_W-1:0]        src, cnt_w;
  logic [POS_W-1:0]        pos_u, d_u, ad_w;
  logic [2*T_W-1:0]        sq;
  logic [T2_W+T_W-1:0]     cube;
  logic signed [KV_W-1:0]  e3, e2, e1, v0, v1, v;
  logic signed [K_W-1:0]   k_new, k_rd;
  logic [K_W-1:0]          kmag;
  logic signed [SUM_W-1:0] smag;
  logic                    sum_zero;
  logic                    inc;
  logic [16:0]             mag;
  logic [14:0]             mag_c;
  logic [HALF_W-1:0]       weight;
  logic                    tap_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      il_r <= LEN_W'(1);
      ol_r <= LEN_W'(1);
    end else if (cfg_valid) begin
      if (cfg_index == REG_INPUT_LENGTH) begin
        il_r <= cfg_data[LEN_W-1:0];
      end else if (cfg_index == REG_OUTPUT_LENGTH) begin
        ol_r <= cfg_data[LEN_W-1:0];
      end
    end
  end

  assign cprod = {dest_r, 1'b1} * il_r;

  // Dividends are left-aligned so that the divider always shifts out the top bit.
  always_comb begin
    div_num   = '0;
    div_steps = STEPS_SCALE;
    div_den   = FS_W'(ol_r);
    case (cmd.div_op)
      DIV_SCALE: begin
        div_num   = {il_r, {(NUM_W-LEN_W){1'b0}}};
        div_steps = STEPS_SCALE;
        div_den   = FS_W'(ol_r);
      end
      DIV_CENTRE: begin
        div_num   = {cprod, {(NUM_W-2*LEN_W){1'b0}}};
        div_steps = STEPS_CENTRE;
        div_den   = FS_W'(ol_r);
      end
      DIV_TAP: begin
        div_num   = {ad_r, {(NUM_W-AD_W){1'b0}}};
        div_steps = STEPS_TAP;
        div_den   = fs_r;
      end
      DIV_RATIO: begin
        div_num   = {kmag, {(NUM_W-K_W){1'b0}}};
        div_steps = STEPS_RATIO;
        div_den   = sum_zero ? FS_W'(64'd1 << 30) : smag[FS_W-1:0];
      end
      default: begin
        div_num = '0;
      end
    endcase
  end

  bcaa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .num      (div_num),
    .steps    (div_steps),
    .divisor  (div_den),
    .busy     (div_busy),
    .done     (div_done),
    .step_bit (div_bit),
    .quo      (div_quo),
    .rem_nz   (div_rem_nz)
  );

  bcaa_ram #(
    .WIDTH (K_W),
    .DEPTH (MAX_TAPS)
  ) u_taps (
    .clk   (clk),
    .we    (cmd.kern_wr),
    .waddr (idx_r[ADDR_W-1:0]),
    .wdata (k_new),
    .re    (cmd.rd_tap),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign src   = xmin_r + COL_W'(idx_r);
  assign pos_u = {1'b0, src, 24'h800000};
  assign d_u   = pos_u - POS_W'(centre_r);
  assign ad_w  = d_u[POS_W-1] ? (~d_u + 1'b1) : d_u;
  assign cnt_w = xmax_r - xmin_r;

  assign sq   = t_r * t_r;
  assign cube = t2_r * t_r;

  // Keys kernel with a = -0.5, both branches in Q2.30 before the final halving.
  assign e3 = KV_W'(t3_r);
  assign e2 = KV_W'(t2_r);
  assign e1 = KV_W'({t_r, 9'b0});
  assign v0 = (e3 <<< 1) + e3 - (e2 <<< 2) - e2 + (KV_W'(1) <<< 31);
  assign v1 = (e2 <<< 2) + e2 - e3 - e1 + (KV_W'(1) <<< 32);
  assign v  = t_r[T_W-1] ? v1 : v0;
  assign k_new = inr_r ? v[K_W:1] : '0;

  assign k_rd     = ram_rdata;
  assign kmag     = k_rd[K_W-1] ? (~ram_rdata + 1'b1) : ram_rdata;
  assign sum_zero = (sum_r == '0);
  assign smag     = sum_r[SUM_W-1] ? -sum_r : sum_r;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      dest_r <= in_tdata[DEST_W-1:0];
    end
    if (cmd.cap_scale) begin
      fs_r <= (div_quo < QUO_W'(64'd1 << 24)) ? FS_W'(64'd1 << 24) : div_quo[FS_W-1:0];
    end
    if (cmd.cap_centre) begin
      centre_r <= div_quo[FS_W-1:0];
    end
    if (cmd.calc_bounds) begin
      lo_r <= $signed(POS_W'(centre_r)) - $signed(POS_W'({fs_r, 1'b0}))
              + $signed(POS_W'(64'd1 << 23));
      hi_r <= POS_W'(centre_r) + POS_W'({fs_r, 1'b0}) + POS_W'(64'd1 << 23);
    end
    if (cmd.calc_range) begin
      xmin_r <= lo_r[POS_W-1] ? '0 : lo_r[24+COL_W-1:24];
      xmax_r <= (hi_r[24+COL_W-1:24] > COL_W'(il_r)) ? COL_W'(il_r) : hi_r[24+COL_W-1:24];
    end
    if (cmd.tap_dist) begin
      ad_r  <= ad_w[AD_W-1:0];
      inr_r <= ad_w[AD_W-1:0] < {fs_r, 1'b0};
    end
    if (cmd.cap_t) begin
      t_r <= div_quo[T_W-1:0];
    end
    if (cmd.mul_sq) begin
      t2_r <= sq[18+T2_W-1:18];
    end
    if (cmd.mul_cube) begin
      t3_r <= cube[24+T3_W-1:24];
    end
    if (cmd.tap_init) begin
      sum_r <= '0;
    end else if (cmd.kern_wr) begin
      sum_r <= sum_r + SUM_W'(k_new);
    end
    if (cmd.tap_init || cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.kern_wr || cmd.emit) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // Quotient bits arrive MSB first. Eleven bits are kept from the leading one, or from
  // bit eleven when the quotient is smaller (subnormal), then a round bit and a sticky OR.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      op_r      <= cmd.div_op;
      neg_r     <= k_rd[K_W-1] ^ sum_r[SUM_W-1];
      kzero_r   <= (ram_rdata == '0);
      started_r <= 1'b0;
      rb_got_r  <= 1'b0;
      rb_r      <= 1'b0;
      stk_r     <= 1'b0;
      keep_r    <= '0;
      kcnt_r    <= '0;
      exp_r     <= '0;
      bpos_r    <= RATIO_TOP;
    end else if (div_busy && op_r == DIV_RATIO) begin
      bpos_r <= bpos_r - 1'b1;
      if (!started_r) begin
        if (div_bit || bpos_r == KEEP_POS) begin
          started_r <= 1'b1;
          exp_r     <= bpos_r - KEEP_POS;
          keep_r    <= KEEP_W'(div_bit);
          kcnt_r    <= 4'd1;
        end
      end else if (kcnt_r != 4'(KEEP_W)) begin
        keep_r <= {keep_r[KEEP_W-2:0], div_bit};
        kcnt_r <= kcnt_r + 1'b1;
      end else if (!rb_got_r) begin
        rb_r     <= div_bit;
        rb_got_r <= 1'b1;
      end else begin
        stk_r <= stk_r | div_bit;
      end
    end
  end

  assign inc    = rb_r & (stk_r | div_rem_nz | keep_r[0]);
  assign mag    = {1'b0, exp_r, 10'b0} + 17'(keep_r) + 17'(inc);
  assign mag_c  = (mag > 17'h07C00) ? 15'h7C00 : mag[14:0];
  assign weight = kzero_r ? '0 : {neg_r, mag_c};

  assign tap_last = (IDX_W'(idx_r + 1'b1) == cnt_w[IDX_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.emit_bad) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_src_r  <= src[SRC_W-1:0];
      out_w_r    <= weight;
      out_last_r <= tap_last;
      out_bad_r  <= 1'b0;
    end else if (cmd.emit_bad) begin
      out_src_r  <= '0;
      out_w_r    <= '0;
      out_last_r <= 1'b1;
      out_bad_r  <= 1'b1;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {{(OUT_TDATA_W-HALF_W-SRC_W){1'b0}}, out_w_r, out_src_r};
  assign out_tuser[0] = out_bad_r;
  assign out_tlast    = out_last_r;

  assign st.req_bad   = (il_r == '0) || (ol_r == '0) || (32'(il_r) > MAX_LENGTH)
                        || (32'(ol_r) > MAX_LENGTH) || ({1'b0, dest_r} >= ol_r);
  assign st.range_bad = (xmax_r <= xmin_r) || (cnt_w > COL_W'(MAX_TAPS));
  assign st.div_busy  = div_busy;
  assign st.div_done  = div_done;
  assign st.tap_last  = tap_last;
  assign st.out_free  = !out_valid_r || out_tready;

endmodule

// ===== rtl/core/bcaa_ctrl.sv =====
// Controller state machine sequencing setup, the kernel pass and the weight pass.
`include "assert_macros.svh"

module bcaa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  bcaa_pkg::status_t   st,
  output bcaa_pkg::cmd_t      cmd
);
  import bcaa_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CHECK  = 5'd1;
  localparam logic [4:0] S_SCALE  = 5'd2;
  localparam logic [4:0] S_CENTRE = 5'd3;
  localparam logic [4:0] S_BOUNDS = 5'd4;
  localparam logic [4:0] S_RANGE  = 5'd5;
  localparam logic [4:0] S_RCHECK = 5'd6;
  localparam logic [4:0] S_DIST   = 5'd7;
  localparam logic [4:0] S_TSTART = 5'd8;
  localparam logic [4:0] S_TWAIT  = 5'd9;
  localparam logic [4:0] S_SQ     = 5'd10;
  localparam logic [4:0] S_CUBE   = 5'd11;
  localparam logic [4:0] S_KERN   = 5'd12;
  localparam logic [4:0] S_PASS2  = 5'd13;
  localparam logic [4:0] S_RD     = 5'd14;
  localparam logic [4:0] S_CSTART = 5'd15;
  localparam logic [4:0] S_CWAIT  = 5'd16;
  localparam logic [4:0] S_EMIT   = 5'd17;
  localparam logic [4:0] S_BAD    = 5'd18;

  logic [4:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.req_bad) begin
          state_nxt = S_BAD;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_op    = DIV_SCALE;
          state_nxt     = S_SCALE;
        end
      end
      S_SCALE: begin
        if (st.div_done) begin
          cmd.cap_scale = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_op    = DIV_CENTRE;
          state_nxt     = S_CENTRE;
        end
      end
      S_CENTRE: begin
        if (st.div_done) begin
          cmd.cap_centre = 1'b1;
          state_nxt      = S_BOUNDS;
        end
      end
      S_BOUNDS: begin
        cmd.calc_bounds = 1'b1;
        state_nxt       = S_RANGE;
      end
      S_RANGE: begin
        cmd.calc_range = 1'b1;
        state_nxt      = S_RCHECK;
      end
      S_RCHECK: begin
        if (st.range_bad) begin
          state_nxt = S_BAD;
        end else begin
          cmd.tap_init = 1'b1;
          state_nxt    = S_DIST;
        end
      end
      S_DIST: begin
        cmd.tap_dist = 1'b1;
        state_nxt    = S_TSTART;
      end
      S_TSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_TAP;
        state_nxt     = S_TWAIT;
      end
      S_TWAIT: begin
        if (st.div_done) begin
          cmd.cap_t = 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.mul_sq = 1'b1;
        state_nxt  = S_CUBE;
      end
      S_CUBE: begin
        cmd.mul_cube = 1'b1;
        state_nxt    = S_KERN;
      end
      S_KERN: begin
        cmd.kern_wr = 1'b1;
        state_nxt   = st.tap_last ? S_PASS2 : S_DIST;
      end
      S_PASS2: begin
        cmd.idx_clr = 1'b1;
        state_nxt   = S_RD;
      end
      S_RD: begin
        cmd.rd_tap = 1'b1;
        state_nxt  = S_CSTART;
      end
      S_CSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_RATIO;
        state_nxt     = S_CWAIT;
      end
      S_CWAIT: begin
        if (st.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = st.tap_last ? S_IDLE : S_RD;
        end
      end
      S_BAD: begin
        if (st.out_free) begin
          cmd.emit_bad = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_NEVER(a_div_start_busy, clk, rst_n, cmd.div_start && st.div_busy, "divider restarted while busy")
  `ASSERT_NEVER(a_emit_full, clk, rst_n, (cmd.emit || cmd.emit_bad) && !st.out_free, "output register overwritten")
  `ASSERT_PROP(a_last_idle, clk, rst_n, cmd.emit && st.tap_last |=> state_r == S_IDLE, "last tap did not end the request")

endmodule
